>>> rtl/assert_macros.svh
// Assertion macros used by dwra_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/dwra_pkg.sv
`timescale 1ns / 1ps

package dwra_pkg;

    localparam int CFG_W           = 8;
    localparam int DELAY_W         = 7;
    localparam int WEIGHT_W        = 16;
    localparam int OUT_W           = 24;
    localparam int STATUS_W        = 2;
    localparam int ZERO_SIZE_BINS  = 10;
    localparam int RESET_RING_SIZE = 20;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DROP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic restart;
        logic clear;
        logic accept;
        logic rd;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
    } t_dp_stat;

endpackage

>>> rtl/dwra_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dwra_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dwra_pkg::t_dp_cmd  o_cmd,
    input  dwra_pkg::t_dp_stat i_stat
);
    import dwra_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CALC
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    t_dp_cmd cmd;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        cmd         = '0;
        cmd.restart = i_cfg_we;
        case (r_state)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                cmd.rd  = 1'b1;
                n_state = S_CALC;
            end
            S_CALC: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.commit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        if (i_cfg_we) begin
            n_state = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    `ASSERT_NEXT(a_accept_reads, i_clk, i_rst_n, cmd.accept && !i_cfg_we, r_state == S_READ)
    `ASSERT_NEXT(a_commit_valid, i_clk, i_rst_n, cmd.commit, r_out_valid)
    `ASSERT_NEXT(a_calc_waits, i_clk, i_rst_n, r_state == S_CALC && r_out_valid && i_out_stall && !i_cfg_we, r_state == S_CALC)
    `ASSERT_NEXT(a_clear_ends, i_clk, i_rst_n, cmd.clear && i_stat.clear_last && !i_cfg_we, r_state == S_IDLE)

endmodule

>>> rtl/dwra_dp.sv
`timescale 1ns / 1ps

module dwra_dp #(
    parameter int MAX_BINS  = 128,
    parameter int ACC_WIDTH = 24
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  dwra_pkg::t_dp_cmd                          i_cmd,
    output dwra_pkg::t_dp_stat                         o_stat,
    input  logic [dwra_pkg::CFG_W-1:0]                 i_cfg_data,
    input  logic                                       i_cmd_bit,
    input  logic [dwra_pkg::DELAY_W-1:0]               i_delay_bins,
    input  logic signed [dwra_pkg::WEIGHT_W-1:0]       i_weight,
    output logic signed [dwra_pkg::OUT_W-1:0]          o_bin_sum,
    output logic [dwra_pkg::STATUS_W-1:0]              o_status
);
    import dwra_pkg::*;

    localparam int AW        = $clog2(MAX_BINS);
    localparam int SZW       = $clog2(MAX_BINS + 1);
    localparam int SUMW      = ((AW > DELAY_W) ? AW : DELAY_W) + 1;
    localparam int ZERO_EFF  = (ZERO_SIZE_BINS > MAX_BINS) ? MAX_BINS : ZERO_SIZE_BINS;
    localparam int RESET_EFF = (RESET_RING_SIZE > MAX_BINS) ? MAX_BINS : RESET_RING_SIZE;

    logic signed [ACC_WIDTH-1:0] mem [MAX_BINS];

    logic [SZW-1:0]              r_size;
    logic [SZW-1:0]              n_cfg_size;
    logic [AW-1:0]               r_slot;
    logic [AW-1:0]               r_clr_addr;
    logic                        r_cmd;
    logic [DELAY_W-1:0]          r_delay;
    logic signed [WEIGHT_W-1:0]  r_weight;
    logic [AW-1:0]               r_idx;
    logic                        r_drop;
    logic signed [ACC_WIDTH-1:0] r_rd_data;
    logic signed [OUT_W-1:0]     r_bin_sum;
    logic [STATUS_W-1:0]         r_status;

    logic [SUMW-1:0]             idx_sum;
    logic [SUMW-1:0]             idx_wrap;
    logic [AW-1:0]               n_idx;
    logic                        n_drop;
    logic signed [ACC_WIDTH:0]   add_sum;
    logic                        add_ovf;
    logic signed [ACC_WIDTH-1:0] add_sat;
    logic signed [OUT_W-1:0]     pop_val;
    logic                        pop_clip;
    logic                        mem_we;
    logic [AW-1:0]               mem_wr_addr;
    logic signed [ACC_WIDTH-1:0] mem_wr_data;
    logic                        slot_wrap;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_cfg_size = SZW'(ZERO_EFF);
        end else if (32'(i_cfg_data) > MAX_BINS) begin
            n_cfg_size = SZW'(MAX_BINS);
        end else begin
            n_cfg_size = SZW'(i_cfg_data);
        end
    end

    always_comb begin
        idx_sum  = SUMW'(r_slot) + SUMW'(r_delay);
        idx_wrap = (idx_sum >= SUMW'(r_size)) ? (idx_sum - SUMW'(r_size)) : idx_sum;
        n_drop   = !r_cmd && (SUMW'(r_delay) >= SUMW'(r_size));
        n_idx    = r_cmd ? r_slot : idx_wrap[AW-1:0];
    end

    always_comb begin
        add_sum = (ACC_WIDTH + 1)'(r_rd_data) + (ACC_WIDTH + 1)'(r_weight);
        add_ovf = add_sum[ACC_WIDTH] != add_sum[ACC_WIDTH-1];
        if (!add_ovf) begin
            add_sat = add_sum[ACC_WIDTH-1:0];
        end else if (add_sum[ACC_WIDTH]) begin
            add_sat = {1'b1, {(ACC_WIDTH - 1){1'b0}}};
        end else begin
            add_sat = {1'b0, {(ACC_WIDTH - 1){1'b1}}};
        end
    end

    generate
        if (ACC_WIDTH > OUT_W) begin : g_wide
            logic [ACC_WIDTH-OUT_W:0] upper;
            assign upper    = r_rd_data[ACC_WIDTH-1:OUT_W-1];
            assign pop_clip = !((&upper) || !(|upper));
            assign pop_val  = !pop_clip ? r_rd_data[OUT_W-1:0] :
                              (r_rd_data[ACC_WIDTH-1] ? {1'b1, {(OUT_W - 1){1'b0}}} :
                                                        {1'b0, {(OUT_W - 1){1'b1}}});
        end else begin : g_narrow
            assign pop_clip = 1'b0;
            assign pop_val  = OUT_W'(r_rd_data);
        end
    endgenerate

    always_comb begin
        mem_we      = 1'b0;
        mem_wr_addr = r_idx;
        mem_wr_data = '0;
        if (i_cmd.clear) begin
            mem_we      = 1'b1;
            mem_wr_addr = r_clr_addr;
        end else if (i_cmd.commit && !r_drop) begin
            mem_we      = 1'b1;
            mem_wr_data = r_cmd ? '0 : add_sat;
        end
    end

    assign slot_wrap = ((SZW'(r_slot) + SZW'(1)) == r_size);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[n_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size     <= SZW'(RESET_EFF);
            r_slot     <= '0;
            r_clr_addr <= '0;
        end else if (i_cmd.restart) begin
            r_size     <= n_cfg_size;
            r_slot     <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.commit && r_cmd) begin
                r_slot <= slot_wrap ? '0 : (r_slot + AW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd    <= i_cmd_bit;
            r_delay  <= i_delay_bins;
            r_weight <= i_weight;
        end
        if (i_cmd.rd) begin
            r_idx  <= n_idx;
            r_drop <= n_drop;
        end
        if (i_cmd.commit) begin
            if (r_cmd) begin
                r_bin_sum <= pop_val;
                r_status  <= pop_clip ? ST_SAT : ST_OK;
            end else begin
                r_bin_sum <= '0;
                r_status  <= r_drop ? ST_DROP : (add_ovf ? ST_SAT : ST_OK);
            end
        end
    end

    assign o_stat.clear_last = (r_clr_addr == AW'(MAX_BINS - 1));
    assign o_bin_sum         = r_bin_sum;
    assign o_status          = r_status;

endmodule

>>> rtl/delayed_weight_ring_accumulator_core.sv
`timescale 1ns / 1ps
// Each accepted item is read from its bin in READ (registered read), then
// added and written back in CALC, which commits the registered result and waits
// while a held output is stalled; new items stall until the block is in IDLE.
// Reset and every ring_size write start a clearing pass that zeroes all MAX_BINS
// bins and the current slot; input items are stalled until it ends.

module delayed_weight_ring_accumulator_core #(
    parameter int MAX_BINS  = 128,
    parameter int ACC_WIDTH = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [dwra_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_cmd,
    input  logic [dwra_pkg::DELAY_W-1:0]         i_delay_bins,
    input  logic signed [dwra_pkg::WEIGHT_W-1:0] i_weight,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [dwra_pkg::OUT_W-1:0]    o_bin_sum,
    output logic [dwra_pkg::STATUS_W-1:0]        o_status
);
    import dwra_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    dwra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    dwra_dp #(
        .MAX_BINS  (MAX_BINS),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_cfg_data   (i_cfg_data),
        .i_cmd_bit    (i_cmd),
        .i_delay_bins (i_delay_bins),
        .i_weight     (i_weight),
        .o_bin_sum    (o_bin_sum),
        .o_status     (o_status)
    );

endmodule
